>>> src/dda_pkg.sv
// Package for the DDA line rasterizer: fixed field widths, opcodes and the
// widths that follow from the Q12.4 endpoint format. No dependencies.
package dda_pkg;

    localparam int IN_W     = 16;  // Q12.4 endpoint coordinate
    localparam int IN_FRAC  = 4;
    localparam int DELTA_W  = 17;  // difference of two endpoints
    localparam int MAG_W    = 16;  // magnitude of a delta, at most 65535
    localparam int COUNT_W  = 12;  // pixels still to come after the current one
    localparam int COLOUR_W = 24;

    localparam logic [COLOUR_W-1:0] COLOUR_RESET = 24'hFFFFFF;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

endpackage

>>> src/dda_line_rasterizer.sv
// Latency: a step item shows its pixel in the output register the cycle after its transfer.
// Throughput: one step item per cycle while the output is taken; a load runs the shared
// restoring divider for the two increments, the x increment and then the y increment.
// The block holds in_ready low while the divider iterates; a zero-length line skips it.
// Reset (asynchronous, active low) clears the line state and sets the colour to white.
// Top level of the DDA line rasterizer; depends on dda_pkg.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 12
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [COLOUR_W-1:0]        cfg_data,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       op,
    input  logic signed [IN_W-1:0]     start_x,
    input  logic signed [IN_W-1:0]     start_y,
    input  logic signed [IN_W-1:0]     end_x,
    input  logic signed [IN_W-1:0]     end_y,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [INT_BITS-1:0] pixel_x,
    output logic signed [INT_BITS-1:0] pixel_y,
    output logic [COLOUR_W-1:0]        colour,
    output logic                       valid_res,
    output logic                       last
);

    // Integer part of the position: endpoint range plus the half-pixel bias and a sign bit.
    localparam int PINT_MIN = IN_W - IN_FRAC + 2;
    localparam int PINT_W   = (INT_BITS > PINT_MIN) ? INT_BITS : PINT_MIN;
    localparam int POS_W    = PINT_W + FRAC_BITS;
    localparam int STEP_W   = FRAC_BITS + 2;
    localparam int Q_W      = FRAC_BITS + 1;
    localparam int CNT_W    = $clog2(FRAC_BITS + 1);
    localparam int SHIFT    = FRAC_BITS - IN_FRAC;

    localparam logic [CNT_W-1:0]        CNT_LAST = CNT_W'(FRAC_BITS);
    localparam logic signed [POS_W-1:0] HALF     = POS_W'(1) <<< (FRAC_BITS - 1);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

    state_t                     state_reg, state_next;
    logic [COLOUR_W-1:0]        colour_reg, colour_next;
    logic signed [POS_W-1:0]    pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0]    pos_y_reg, pos_y_next;
    logic signed [STEP_W-1:0]   step_x_reg, step_x_next;
    logic signed [STEP_W-1:0]   step_y_reg, step_y_next;
    logic [COUNT_W-1:0]         pixels_left_reg, pixels_left_next;
    logic                       line_active_reg, line_active_next;

    // Shared divider state
    logic [MAG_W:0]             rem_reg, rem_next;
    logic [MAG_W-1:0]           span_reg, span_next;
    logic [MAG_W-1:0]           ay_reg, ay_next;
    logic                       neg_x_reg, neg_x_next;
    logic                       neg_y_reg, neg_y_next;
    logic [Q_W-1:0]             quo_reg, quo_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic [INT_BITS-1:0]        pix_x_reg, pix_x_next;
    logic [INT_BITS-1:0]        pix_y_reg, pix_y_next;
    logic [COLOUR_W-1:0]        out_colour_reg, out_colour_next;
    logic                       valid_res_reg, valid_res_next;
    logic                       last_reg, last_next;

    logic                       in_fire;
    logic signed [DELTA_W-1:0]  dx, dy;
    logic [DELTA_W-1:0]         ndx, ndy;
    logic [MAG_W-1:0]           ax, ay, span_w;
    logic signed [POS_W-1:0]    base_x, base_y;
    logic                       div_ge;
    logic [MAG_W:0]             div_diff;
    logic [Q_W-1:0]             div_quo;
    logic signed [STEP_W-1:0]   quo_ext;
    logic signed [STEP_W-1:0]   quo_neg;

    function automatic logic [INT_BITS-1:0] trunc_pix(input logic signed [POS_W-1:0] p);
        logic signed [PINT_W-1:0] ip;
        ip = p[POS_W-1:FRAC_BITS];
        // Floor plus one gives truncation toward zero for a negative value with a fraction.
        if (p[POS_W-1] && (p[FRAC_BITS-1:0] != '0))
        begin
            ip = ip + PINT_W'(1);
        end
        return ip[INT_BITS-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign pixel_x   = pix_x_reg;
    assign pixel_y   = pix_y_reg;
    assign colour    = out_colour_reg;
    assign valid_res = valid_res_reg;
    assign last      = last_reg;

    always_comb
    begin
        dx     = DELTA_W'(end_x) - DELTA_W'(start_x);
        dy     = DELTA_W'(end_y) - DELTA_W'(start_y);
        ndx    = -dx;
        ndy    = -dy;
        ax     = dx[DELTA_W-1] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
        ay     = dy[DELTA_W-1] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
        span_w = (ax > ay) ? ax : ay;

        base_x = POS_W'(start_x) <<< SHIFT;
        base_y = POS_W'(start_y) <<< SHIFT;
        if (dx > 0)
        begin
            base_x = base_x + HALF;
        end
        else if (dx < 0)
        begin
            base_x = base_x - HALF;
        end
        if (dy > 0)
        begin
            base_y = base_y + HALF;
        end
        else if (dy < 0)
        begin
            base_y = base_y - HALF;
        end

        // One restoring step: compare, subtract, shift in a quotient bit.
        div_ge   = rem_reg >= {1'b0, span_reg};
        div_diff = div_ge ? (rem_reg - {1'b0, span_reg}) : rem_reg;
        div_quo  = {quo_reg[Q_W-2:0], div_ge};
        quo_ext  = STEP_W'(div_quo);
        quo_neg  = -quo_ext;
    end

    always_comb
    begin
        state_next       = state_reg;
        colour_next      = colour_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        step_x_next      = step_x_reg;
        step_y_next      = step_y_reg;
        pixels_left_next = pixels_left_reg;
        line_active_next = line_active_reg;
        rem_next         = rem_reg;
        span_next        = span_reg;
        ay_next          = ay_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pix_x_next       = pix_x_reg;
        pix_y_next       = pix_y_reg;
        out_colour_next  = out_colour_reg;
        valid_res_next   = valid_res_reg;
        last_next        = last_reg;

        if (cfg_valid && cfg_ready)
        begin
            colour_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (op_t'(op) == OP_LOAD))
                begin
                    pos_x_next       = base_x;
                    pos_y_next       = base_y;
                    pixels_left_next = span_w[MAG_W-1:IN_FRAC];
                    line_active_next = 1'b1;
                    span_next        = span_w;
                    ay_next          = ay;
                    neg_x_next       = dx[DELTA_W-1];
                    neg_y_next       = dy[DELTA_W-1];
                    rem_next         = {1'b0, ax};
                    quo_next         = '0;
                    cnt_next         = '0;
                    step_x_next      = '0;
                    step_y_next      = '0;
                    if (span_w != '0)
                    begin
                        state_next = ST_DIV_X;
                    end
                end
                else if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    if (line_active_reg)
                    begin
                        pix_x_next      = trunc_pix(pos_x_reg);
                        pix_y_next      = trunc_pix(pos_y_reg);
                        out_colour_next = colour_reg;
                        valid_res_next  = 1'b1;
                        if (pixels_left_reg == '0)
                        begin
                            last_next        = 1'b1;
                            line_active_next = 1'b0;
                        end
                        else
                        begin
                            last_next        = 1'b0;
                            pixels_left_next = pixels_left_reg - COUNT_W'(1);
                            pos_x_next       = pos_x_reg + POS_W'(step_x_reg);
                            pos_y_next       = pos_y_reg + POS_W'(step_y_reg);
                        end
                    end
                    else
                    begin
                        pix_x_next      = '0;
                        pix_y_next      = '0;
                        out_colour_next = '0;
                        valid_res_next  = 1'b0;
                        last_next       = 1'b0;
                    end
                end
            end

            ST_DIV_X:
            begin
                rem_next = {div_diff[MAG_W-1:0], 1'b0};
                quo_next = div_quo;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    step_x_next = neg_x_reg ? quo_neg : quo_ext;
                    rem_next    = {1'b0, ay_reg};
                    quo_next    = '0;
                    cnt_next    = '0;
                    state_next  = ST_DIV_Y;
                end
            end

            ST_DIV_Y:
            begin
                rem_next = {div_diff[MAG_W-1:0], 1'b0};
                quo_next = div_quo;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    step_y_next = neg_y_reg ? quo_neg : quo_ext;
                    cnt_next    = '0;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            colour_reg      <= COLOUR_RESET;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            pixels_left_reg <= '0;
            line_active_reg <= 1'b0;
            rem_reg         <= '0;
            span_reg        <= '0;
            ay_reg          <= '0;
            neg_x_reg       <= 1'b0;
            neg_y_reg       <= 1'b0;
            quo_reg         <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            pix_x_reg       <= '0;
            pix_y_reg       <= '0;
            out_colour_reg  <= '0;
            valid_res_reg   <= 1'b0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            colour_reg      <= colour_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            step_x_reg      <= step_x_next;
            step_y_reg      <= step_y_next;
            pixels_left_reg <= pixels_left_next;
            line_active_reg <= line_active_next;
            rem_reg         <= rem_next;
            span_reg        <= span_next;
            ay_reg          <= ay_next;
            neg_x_reg       <= neg_x_next;
            neg_y_reg       <= neg_y_next;
            quo_reg         <= quo_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            pix_x_reg       <= pix_x_next;
            pix_y_reg       <= pix_y_next;
            out_colour_reg  <= out_colour_next;
            valid_res_reg   <= valid_res_next;
            last_reg        <= last_next;
        end
    end

    // The partial remainder stays below twice the divisor during the division.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (rem_reg < {span_reg, 1'b0}))
        else $error("divider remainder out of range");

    // A load with a nonzero span starts the x division.
    a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op_t'(op) == OP_LOAD) && (span_w != '0)) |=> (state_reg == ST_DIV_X))
        else $error("load did not start the divider");

    // The final pixel of a line ends it.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op_t'(op) == OP_STEP) && line_active_reg && (pixels_left_reg == '0))
        |=> (!line_active_reg && last_reg && valid_res_reg))
        else $error("last pixel did not end the line");

    // A division only runs for an active line.
    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> line_active_reg)
        else $error("divider running with no line");

endmodule

>>> tb/dda_line_rasterizer_test.sv
`timescale 1ns / 100ps
// Testbench for dda_line_rasterizer: a directed table, then random line runs and noise,
// every pixel transfer checked against a typed expectation or a line predictor. Depends on dda_pkg and the RTL.
module dda_line_rasterizer_test
    import dda_pkg::*;
();

    localparam int FRAC        = 16;
    localparam int PIX_W       = 12;
    localparam int SETTLE_CYC  = 2 * (FRAC + 1) + 6;
    localparam int PHASE_ITEMS = 475;

    typedef struct packed {
        logic signed [PIX_W-1:0] x;
        logic signed [PIX_W-1:0] y;
        logic [COLOUR_W-1:0]     rgb;
        logic                    on;
        logic                    fin;
    } pixel_t;

    typedef struct {
        op_t                    kind;
        logic signed [IN_W-1:0] sx;
        logic signed [IN_W-1:0] sy;
        logic signed [IN_W-1:0] ex;
        logic signed [IN_W-1:0] ey;
        bit                     typed;
        pixel_t                 want;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [COLOUR_W-1:0]        cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    op_t                        op;
    logic signed [IN_W-1:0]     start_x;
    logic signed [IN_W-1:0]     start_y;
    logic signed [IN_W-1:0]     end_x;
    logic signed [IN_W-1:0]     end_y;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [PIX_W-1:0]    pixel_x;
    logic signed [PIX_W-1:0]    pixel_y;
    logic [COLOUR_W-1:0]        colour;
    logic                       valid_res;
    logic                       last;

    // Line predictor state.
    longint              cur_x = 0;
    longint              cur_y = 0;
    longint              inc_x = 0;
    longint              inc_y = 0;
    int unsigned         remaining = 0;
    bit                  drawing = 1'b0;
    logic [COLOUR_W-1:0] pen = COLOUR_RESET;

    pixel_t    pix_q[$];
    stim_row_t dir_rows[$];
    int        mismatches = 0;
    int        items_sent = 0;
    bit        quiet_in = 1'b0;
    bit        quiet_out = 1'b0;

    dda_line_rasterizer #(
        .FRAC_BITS(FRAC),
        .INT_BITS (PIX_W)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .colour   (colour),
        .valid_res(valid_res),
        .last     (last)
    );

    always #2 clk = ~clk;

    function automatic longint scaled_step(longint d, longint span);
        longint q;
        q = ((d < 0 ? -d : d) <<< FRAC) / span;
        return d < 0 ? -q : q;
    endfunction

    // Start point in FRAC fraction bits, moved half a pixel along the delta.
    function automatic longint biased_start(logic signed [IN_W-1:0] s, longint d);
        longint p;
        p = longint'(s) * (longint'(1) <<< (FRAC - IN_FRAC));
        if (d > 0)
        begin
            p += longint'(1) <<< (FRAC - 1);
        end
        else if (d < 0)
        begin
            p -= longint'(1) <<< (FRAC - 1);
        end
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] pixel_of(longint p);
        longint m;
        longint r;
        m = (p < 0 ? -p : p) >>> FRAC;
        r = p < 0 ? -m : m;
        return r[PIX_W-1:0];
    endfunction

    function automatic bit predict_pixel(input op_t kind,
                                         input logic signed [IN_W-1:0] sx, sy, ex, ey,
                                         output pixel_t px);
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        longint span;
        px = '0;
        if (kind == OP_LOAD)
        begin
            dx = longint'(ex) - longint'(sx);
            dy = longint'(ey) - longint'(sy);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            span = ax > ay ? ax : ay;
            inc_x = span == 0 ? 0 : scaled_step(dx, span);
            inc_y = span == 0 ? 0 : scaled_step(dy, span);
            cur_x = biased_start(sx, dx);
            cur_y = biased_start(sy, dy);
            remaining = int'((span >>> IN_FRAC) & ((1 << COUNT_W) - 1));
            drawing = 1'b1;
            return 1'b0;
        end
        if (drawing)
        begin
            px.x = pixel_of(cur_x);
            px.y = pixel_of(cur_y);
            px.rgb = pen;
            px.on = 1'b1;
            px.fin = remaining == 0;
            if (remaining == 0)
            begin
                drawing = 1'b0;
            end
            else
            begin
                remaining--;
                cur_x += inc_x;
                cur_y += inc_y;
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic signed [IN_W-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        return r[IN_W-1:0];
    endfunction

    function automatic logic signed [IN_W-1:0] clip_coord(int v);
        logic [31:0] r;
        if (v > 32767)
        begin
            v = 32767;
        end
        else if (v < -32768)
        begin
            v = -32768;
        end
        r = v;
        return r[IN_W-1:0];
    endfunction

    function automatic pixel_t mk_pixel(int x, int y, logic [COLOUR_W-1:0] rgb, bit on, bit fin);
        pixel_t p;
        p.x = x[PIX_W-1:0];
        p.y = y[PIX_W-1:0];
        p.rgb = rgb;
        p.on = on;
        p.fin = fin;
        return p;
    endfunction

    function automatic void add_row(op_t kind, int sx, int sy, int ex, int ey,
                                    bit typed, pixel_t want);
        stim_row_t r;
        r.kind = kind;
        r.sx = clip_coord(sx);
        r.sy = clip_coord(sy);
        r.ex = clip_coord(ex);
        r.ey = clip_coord(ey);
        r.typed = typed;
        r.want = want;
        dir_rows.push_back(r);
    endfunction

    // Called at a rising edge; returns at the edge of the transfer with in_valid still high.
    task automatic send_item(input op_t kind, input logic signed [IN_W-1:0] sx, sy, ex, ey,
                             input bit typed, input pixel_t want);
        int     gap;
        bit     hit;
        pixel_t px;
        gap = pick_gap(quiet_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        do
        begin
            @(negedge clk);
            hit = in_ready;
            @(posedge clk);
        end
        while (!hit);
        items_sent++;
        if (predict_pixel(kind, sx, sy, ex, ey, px))
        begin
            pix_q.push_back(typed ? want : px);
        end
    endtask

    // Waits for every pending pixel, then long enough for a trailing division to finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (pix_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_colour(logic [COLOUR_W-1:0] rgb);
        bit hit;
        cfg_valid <= 1'b1;
        cfg_data <= rgb;
        do
        begin
            @(negedge clk);
            hit = cfg_ready;
            @(posedge clk);
        end
        while (!hit);
        cfg_valid <= 1'b0;
        pen = rgb;
    endtask

    // One load, then enough steps to reach the end of the line and a little past it, or fewer,
    // now and then or when the line is long, so the next load replaces a line in progress.
    task automatic run_line();
        logic signed [IN_W-1:0] sx;
        logic signed [IN_W-1:0] sy;
        logic signed [IN_W-1:0] ex;
        logic signed [IN_W-1:0] ey;
        int reach;
        int ax;
        int ay;
        int pixels;
        int steps;
        if ($urandom_range(0, 39) == 0)
        begin
            reach = 65535;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            reach = 1023;
        end
        else
        begin
            reach = 160;
        end
        sx = rand_coord();
        sy = rand_coord();
        ex = clip_coord(int'(sx) + int'($urandom_range(0, 2 * reach)) - reach);
        ey = clip_coord(int'(sy) + int'($urandom_range(0, 2 * reach)) - reach);
        case ($urandom_range(0, 11))
            0: begin ex = sx; ey = sy; end
            1: ey = sy;
            2: ex = sx;
            default: ;
        endcase
        ax = int'(ex) - int'(sx);
        ay = int'(ey) - int'(sy);
        ax = ax < 0 ? -ax : ax;
        ay = ay < 0 ? -ay : ay;
        pixels = ((ax > ay ? ax : ay) >> IN_FRAC) + 1;
        if ($urandom_range(0, 4) == 0)
        begin
            steps = $urandom_range(0, pixels);
        end
        else
        begin
            steps = pixels + $urandom_range(0, 2);
        end
        if (steps > 72)
        begin
            steps = $urandom_range(8, 40);
        end
        send_item(OP_LOAD, sx, sy, ex, ey, 1'b0, '0);
        repeat (steps)
        begin
            send_item(OP_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
        end
    endtask

    task automatic run_noise();
        repeat ($urandom_range(1, 4))
        begin
            send_item(op_t'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), 1'b0, '0);
        end
    endtask

    task automatic run_phase(logic [COLOUR_W-1:0] rgb);
        int goal;
        settle();
        set_colour(rgb);
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                quiet_in = $urandom_range(0, 3) == 0;
                quiet_out = $urandom_range(0, 3) == 0;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                run_line();
            end
            else
            begin
                run_noise();
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_LOAD;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;

        // Directed rows; typed expectations hold where the pixel is plain to see.
        add_row(OP_STEP, 0, 0, 0, 0, 1'b1, mk_pixel(0, 0, 0, 0, 0));
        add_row(OP_LOAD, 48, 80, 48, 80, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b1, mk_pixel(3, 5, COLOUR_RESET, 1, 1));
        add_row(OP_STEP, 0, 0, 0, 0, 1'b1, mk_pixel(0, 0, 0, 0, 0));
        add_row(OP_LOAD, -32768, -32768, -32768, 32767, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b1, mk_pixel(-2048, -2047, COLOUR_RESET, 1, 0));
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        // A new load in the middle of a line; the biased start lands on 2048 and wraps.
        add_row(OP_LOAD, 32760, 0, 32767, 0, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b1, mk_pixel(-2048, 0, COLOUR_RESET, 1, 1));
        add_row(OP_LOAD, 32767, 32767, 32767, -32768, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b1, mk_pixel(2047, 2047, COLOUR_RESET, 1, 0));
        add_row(OP_LOAD, 0, 0, -16, -16, 1'b0, '0);
        add_row(OP_STEP, -1, -1, -1, -1, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_LOAD, 32767, 32767, -32768, -32768, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_LOAD, 5, -7, 37, 300, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_LOAD, 100, 100, -3, 90, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);
        add_row(OP_STEP, 0, 0, 0, 0, 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].kind, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                      dir_rows[i].ey, dir_rows[i].typed, dir_rows[i].want);
        end

        run_phase(24'h000000);
        run_phase(24'hFFFFFF);
        run_phase($urandom_range(1, 24'hFFFFFE));
        run_phase($urandom_range(1, 24'hFFFFFE));

        settle();
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin : pixel_sink
        int     stall;
        bit     hit;
        pixel_t seen;
        pixel_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = pick_gap(quiet_out);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                hit = out_valid === 1'b1;
                seen.x = pixel_x;
                seen.y = pixel_y;
                seen.rgb = colour;
                seen.on = valid_res;
                seen.fin = last;
                @(posedge clk);
            end
            while (!hit);
            if (pix_q.size() == 0)
            begin
                $display("%0t ns: unexpected pixel transfer, expected none, got x=%0d y=%0d",
                         $time, seen.x, seen.y);
                mismatches++;
            end
            else
            begin
                want = pix_q.pop_front();
                check_field("pixel_x", 32'(want.x), 32'(seen.x));
                check_field("pixel_y", 32'(want.y), 32'(seen.y));
                check_field("colour", 32'(want.rgb), 32'(seen.rgb));
                check_field("valid_res", 32'(want.on), 32'(seen.on));
                check_field("last", 32'(want.fin), 32'(seen.fin));
            end
        end
    end

    initial
    begin : watchdog
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
